// ===== design/mandelbrot_escape_time_pixel_defines.svh =====
// Assertion macros for the escape-time pixel controller (mbep_ctrl).
`ifndef MANDELBROT_ESCAPE_TIME_PIXEL_DEFINES_SVH
`define MANDELBROT_ESCAPE_TIME_PIXEL_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define MBEP_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset
`define MBEP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/mbep_pkg.sv =====
// Shared constants and controller/datapath interface types for the escape-time pixel block.
`default_nettype none

package mbep_pkg;

   // Parameter defaults
   localparam int MAX_ITER_DEF  = 255;
   localparam int FRAC_BITS_DEF = 24;
   localparam int SIZE_BITS_DEF = 12;

   // Configuration register reset values and indexes
   localparam int WIDTH_RESET    = 600;
   localparam int HEIGHT_RESET   = 400;
   localparam int CSR_INDEX_BITS = 2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_HEIGHT = 2'd1;

   // Reported count: fixed 8-bit field, saturating
   localparam int COUNT_BITS = 8;
   localparam int COUNT_MAX  = 255;

   // Divider operand select
   localparam logic DIV_SEL_RE = 1'b0;
   localparam logic DIV_SEL_IM = 1'b1;

   // Controller to datapath commands
   typedef struct packed {
      logic load;       // capture pixel, clear z and count
      logic div_init;   // load divider with selected numerator
      logic div_sel;    // DIV_SEL_RE or DIV_SEL_IM
      logic div_step;   // one restoring-division step
      logic store_re;   // latch saturated quotient into c_re
      logic store_im;   // latch saturated quotient into c_im
      logic mul;        // register the three products
      logic upd;        // z = z*z + c, count + 1
      logic out_load;   // load result register
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic div_last;   // current step is the final division step
      logic at_max;     // count has reached the iteration limit
      logic escape;     // |z|^2 >= 4 for the registered products
   } status_type;

endpackage

`default_nettype wire

// ===== design/mbep_ctrl.sv =====
// Sequencing state machine for the escape-time pixel block.
`default_nettype none
`include "mandelbrot_escape_time_pixel_defines.svh"

module mbep_ctrl
   import mbep_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output cmd_type         cmd,
   input  wire status_type status
);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_INIT_RE  = 4'd1;
   localparam logic [3:0] S_DIV_RE   = 4'd2;
   localparam logic [3:0] S_INIT_IM  = 4'd3;
   localparam logic [3:0] S_DIV_IM   = 4'd4;
   localparam logic [3:0] S_STORE_IM = 4'd5;
   localparam logic [3:0] S_MUL      = 4'd6;
   localparam logic [3:0] S_ADD      = 4'd7;
   localparam logic [3:0] S_FINISH   = 4'd8;

   logic [3:0] state_ff;
   logic [3:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_INIT_RE;
            end
         end
         S_INIT_RE: begin
            cmd.div_init = 1'b1;
            cmd.div_sel  = DIV_SEL_RE;
            state_in     = S_DIV_RE;
         end
         S_DIV_RE: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = S_INIT_IM;
            end
         end
         S_INIT_IM: begin
            cmd.store_re = 1'b1;
            cmd.div_init = 1'b1;
            cmd.div_sel  = DIV_SEL_IM;
            state_in     = S_DIV_IM;
         end
         S_DIV_IM: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = S_STORE_IM;
            end
         end
         S_STORE_IM: begin
            cmd.store_im = 1'b1;
            state_in     = S_MUL;
         end
         S_MUL: begin
            if (status.at_max) begin
               state_in = S_FINISH;
            end else begin
               cmd.mul  = 1'b1;
               state_in = S_ADD;
            end
         end
         S_ADD: begin
            if (status.escape) begin
               state_in = S_FINISH;
            end else begin
               cmd.upd  = 1'b1;
               state_in = S_MUL;
            end
         end
         S_FINISH: begin
            // wait until the result register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Result valid: set on load, cleared on transfer
   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `MBEP_ASSERT_IMP(a_out_slot_free, clock, reset, cmd.out_load, !rsp_valid_ff || rsp_ready, "result register overwritten before transfer")
   `MBEP_ASSERT_NEXT(a_accept_starts_div, clock, reset, req_valid && req_ready, state_ff == S_INIT_RE, "accepted pixel did not start division")
   `MBEP_ASSERT_IMP(a_one_datapath_op, clock, reset, 1'b1, $onehot0({cmd.div_init, cmd.div_step, cmd.mul, cmd.upd}), "conflicting datapath commands")
   `MBEP_ASSERT_NEXT(a_load_shows_valid, clock, reset, cmd.out_load, rsp_valid_ff && state_ff == S_IDLE, "result load did not raise valid")

endmodule

`default_nettype wire

// ===== design/mbep_dp.sv =====
// Datapath: config registers, restoring divider for c, and the z*z + c iteration.
`default_nettype none

module mbep_dp
   import mbep_pkg::*;
#(
   parameter int MAX_ITER  = MAX_ITER_DEF,
   parameter int FRAC_BITS = FRAC_BITS_DEF,
   parameter int SIZE_BITS = SIZE_BITS_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_we,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [SIZE_BITS:0]        csr_wdata,
   input  wire logic [SIZE_BITS-1:0]      req_pixel_col,
   input  wire logic [SIZE_BITS-1:0]      req_pixel_row,
   input  wire cmd_type                   cmd,
   output status_type                     status,
   output logic [COUNT_BITS-1:0]          rsp_iteration_count
);

   localparam int VB   = 8 + FRAC_BITS;         // value width
   localparam int PW   = 2 * VB;                // product width
   localparam int SW   = PW + 2;                // width of sums before saturation
   localparam int DW   = SIZE_BITS + 1;         // size register / divisor width
   localparam int NB   = DW + FRAC_BITS + 1;    // dividend and quotient width
   localparam int CNTW = $clog2(NB);
   localparam int NW   = $clog2(MAX_ITER + 1);
   localparam int NXW  = (NW > COUNT_BITS) ? NW : COUNT_BITS;

   localparam logic signed [VB-1:0] VMAX   = {1'b0, {(VB-1){1'b1}}};
   localparam logic signed [VB-1:0] VMIN   = {1'b1, {(VB-1){1'b0}}};
   localparam logic signed [SW-1:0] VMAX_E = {{(SW-VB+1){1'b0}}, {(VB-1){1'b1}}};
   localparam logic signed [SW-1:0] VMIN_E = {{(SW-VB+1){1'b1}}, {(VB-1){1'b0}}};
   localparam logic signed [SW-1:0] FOUR_E = SW'(4) <<< FRAC_BITS;

   function automatic logic signed [VB-1:0] sat_val(input logic signed [SW-1:0] v);
      logic signed [VB-1:0] r;
      if (v > VMAX_E) begin
         r = VMAX;
      end else if (v < VMIN_E) begin
         r = VMIN;
      end else begin
         r = v[VB-1:0];
      end
      return r;
   endfunction

   // Registers
   logic [DW-1:0]           width_ff,   width_in;
   logic [DW-1:0]           height_ff,  height_in;
   logic [SIZE_BITS-1:0]    col_ff,     col_in;
   logic [SIZE_BITS-1:0]    row_ff,     row_in;
   logic [NB-1:0]           num_ff,     num_in;
   logic [DW-1:0]           rem_ff,     rem_in;
   logic [CNTW-1:0]         div_cnt_ff, div_cnt_in;
   logic                    neg_ff,     neg_in;
   logic signed [VB-1:0]    c_re_ff,    c_re_in;
   logic signed [VB-1:0]    c_im_ff,    c_im_in;
   logic signed [VB-1:0]    re_ff,      re_in;
   logic signed [VB-1:0]    im_ff,      im_in;
   logic signed [PW-1:0]    prod_rr_ff, prod_rr_in;
   logic signed [PW-1:0]    prod_ii_ff, prod_ii_in;
   logic signed [PW-1:0]    prod_ri_ff, prod_ri_in;
   logic [NW-1:0]           iter_ff,    iter_in;
   logic [COUNT_BITS-1:0]   count_ff,   count_in;

   // Divider operands
   logic [DW-1:0]   min_size;
   logic [DW-1:0]   divisor;
   logic [DW-1:0]   two_col;
   logic [DW-1:0]   two_row;
   logic            re_neg;
   logic            im_neg;
   logic [DW-1:0]   re_mag;
   logic [DW-1:0]   im_mag;
   logic [DW:0]     rem_shift;
   logic [DW:0]     rem_diff;
   logic            quo_bit;
   logic signed [SW-1:0] quo_ext;
   logic signed [SW-1:0] quo_signed;
   logic signed [VB-1:0] c_sat;

   // Iteration terms
   logic signed [PW-1:0] sq_re;
   logic signed [PW-1:0] sq_im;
   logic signed [PW-1:0] cross_term;
   logic signed [SW-1:0] sum_sq;
   logic signed [SW-1:0] re_sum;
   logic signed [SW-1:0] im_sum;
   logic [NXW-1:0]       iter_ext;

   // Map pixel to signed offset magnitude; zero-size divisor is taken as one
   always_comb begin
      min_size = (width_ff < height_ff) ? width_ff : height_ff;
      divisor  = (min_size == '0) ? DW'(1) : min_size;
      two_col  = {col_ff, 1'b0};
      two_row  = {row_ff, 1'b0};
      re_neg   = (two_col < width_ff);
      re_mag   = re_neg ? (width_ff - two_col) : (two_col - width_ff);
      im_neg   = (height_ff < two_row);
      im_mag   = im_neg ? (two_row - height_ff) : (height_ff - two_row);
   end

   // Restoring division step, then sign and saturate the quotient
   always_comb begin
      rem_shift  = {rem_ff, num_ff[NB-1]};
      quo_bit    = (rem_shift >= {1'b0, divisor});
      rem_diff   = rem_shift - {1'b0, divisor};
      quo_ext    = signed'({{(SW-NB){1'b0}}, num_ff});
      quo_signed = neg_ff ? -quo_ext : quo_ext;
      c_sat      = sat_val(quo_signed);
   end

   // Escape test and next z from the registered products
   always_comb begin
      sq_re      = prod_rr_ff >>> FRAC_BITS;
      sq_im      = prod_ii_ff >>> FRAC_BITS;
      cross_term = prod_ri_ff >>> (FRAC_BITS - 1);
      sum_sq     = SW'(sq_re) + SW'(sq_im);
      re_sum     = SW'(sq_re) - SW'(sq_im) + SW'(c_re_ff);
      im_sum     = SW'(cross_term) + SW'(c_im_ff);
   end

   // Next-state values
   always_comb begin
      width_in   = (csr_we && csr_index == CSR_IMAGE_WIDTH)  ? csr_wdata : width_ff;
      height_in  = (csr_we && csr_index == CSR_IMAGE_HEIGHT) ? csr_wdata : height_ff;
      col_in     = cmd.load ? req_pixel_col : col_ff;
      row_in     = cmd.load ? req_pixel_row : row_ff;

      num_in     = num_ff;
      rem_in     = rem_ff;
      div_cnt_in = div_cnt_ff;
      neg_in     = neg_ff;
      if (cmd.div_init) begin
         num_in     = {((cmd.div_sel == DIV_SEL_IM) ? im_mag : re_mag), (FRAC_BITS+1)'(0)};
         rem_in     = '0;
         div_cnt_in = '0;
         neg_in     = (cmd.div_sel == DIV_SEL_IM) ? im_neg : re_neg;
      end else if (cmd.div_step) begin
         num_in     = {num_ff[NB-2:0], quo_bit};
         rem_in     = quo_bit ? rem_diff[DW-1:0] : rem_shift[DW-1:0];
         div_cnt_in = div_cnt_ff + CNTW'(1);
      end

      c_re_in    = cmd.store_re ? c_sat : c_re_ff;
      c_im_in    = cmd.store_im ? c_sat : c_im_ff;

      prod_rr_in = prod_rr_ff;
      prod_ii_in = prod_ii_ff;
      prod_ri_in = prod_ri_ff;
      if (cmd.mul) begin
         prod_rr_in = PW'(re_ff) * PW'(re_ff);
         prod_ii_in = PW'(im_ff) * PW'(im_ff);
         prod_ri_in = PW'(re_ff) * PW'(im_ff);
      end

      re_in   = re_ff;
      im_in   = im_ff;
      iter_in = iter_ff;
      if (cmd.load) begin
         re_in   = '0;
         im_in   = '0;
         iter_in = '0;
      end else if (cmd.upd) begin
         re_in   = sat_val(re_sum);
         im_in   = sat_val(im_sum);
         iter_in = iter_ff + NW'(1);
      end

      // count above the 8-bit field reports as all ones
      iter_ext = NXW'(iter_ff);
      count_in = count_ff;
      if (cmd.out_load) begin
         count_in = (iter_ext > NXW'(COUNT_MAX)) ? COUNT_BITS'(COUNT_MAX)
                                                 : iter_ext[COUNT_BITS-1:0];
      end
   end

   // Config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DW'(WIDTH_RESET);
         height_ff <= DW'(HEIGHT_RESET);
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      col_ff     <= col_in;
      row_ff     <= row_in;
      num_ff     <= num_in;
      rem_ff     <= rem_in;
      div_cnt_ff <= div_cnt_in;
      neg_ff     <= neg_in;
      c_re_ff    <= c_re_in;
      c_im_ff    <= c_im_in;
      re_ff      <= re_in;
      im_ff      <= im_in;
      prod_rr_ff <= prod_rr_in;
      prod_ii_ff <= prod_ii_in;
      prod_ri_ff <= prod_ri_in;
      iter_ff    <= iter_in;
      count_ff   <= count_in;
   end

   assign status.div_last     = (div_cnt_ff == CNTW'(NB - 1));
   assign status.at_max       = (iter_ff == NW'(MAX_ITER));
   assign status.escape       = (sum_sq >= FOUR_E);
   assign rsp_iteration_count = count_ff;

endmodule

`default_nettype wire

// ===== design/mandelbrot_escape_time_pixel.sv =====
// Mandelbrot escape-time count for one pixel: controller plus fixed-point datapath.
// Per pixel: load, two restoring divisions for c (real part, then imaginary part), then the
//   multiply / update loop, one pass per iteration, until escape or the iteration limit.
// Throughput: one pixel at a time; set by the one-bit-per-cycle restoring divider run twice
//   for c, then a multiply / update loop per iteration.
// A finished result waits in its output register while the next pixel is accepted.
// Reset (synchronous, active high) returns to idle, drops rsp_valid, and sets width 600, height 400.
`default_nettype none

module mandelbrot_escape_time_pixel
   import mbep_pkg::*;
#(
   parameter int MAX_ITER  = MAX_ITER_DEF,
   parameter int FRAC_BITS = FRAC_BITS_DEF,
   parameter int SIZE_BITS = SIZE_BITS_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_we,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [SIZE_BITS:0]        csr_wdata,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic [SIZE_BITS-1:0]      req_pixel_col,
   input  wire logic [SIZE_BITS-1:0]      req_pixel_row,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic [COUNT_BITS-1:0]          rsp_iteration_count
);

   cmd_type    cmd;
   status_type status;

   // Sequencer
   mbep_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   // Arithmetic and config registers
   mbep_dp #(
      .MAX_ITER  (MAX_ITER),
      .FRAC_BITS (FRAC_BITS),
      .SIZE_BITS (SIZE_BITS)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_pixel_col       (req_pixel_col),
      .req_pixel_row       (req_pixel_row),
      .cmd                 (cmd),
      .status              (status),
      .rsp_iteration_count (rsp_iteration_count)
   );

endmodule

`default_nettype wire

// ===== test/mandelbrot_escape_time_pixel_checker.sv =====
// Checker for the escape-time pixel block: tracks the image size, predicts each count, compares.
`timescale 1ns / 100ps

module mandelbrot_escape_time_pixel_checker
   import mbep_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [SIZE_BITS_DEF:0]    csr_wdata,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  logic [SIZE_BITS_DEF-1:0]  req_pixel_col,
   input  logic [SIZE_BITS_DEF-1:0]  req_pixel_row,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  logic [COUNT_BITS-1:0]     rsp_iteration_count,
   output int                        fail_count,
   output int                        pending_count
);

   // Q8.FRAC fixed point: total width 8 + FRAC, FRAC fraction bits
   localparam int     FRAC         = FRAC_BITS_DEF;
   localparam longint VAL_HI       = (longint'(1) << (FRAC + 7)) - 1;
   localparam longint VAL_LO       = -VAL_HI - 1;
   localparam longint C_UNIT       = longint'(1) << (FRAC + 1);
   localparam longint ESCAPE_LIMIT = longint'(4) << FRAC;

   typedef struct packed {
      logic [SIZE_BITS_DEF-1:0] col;
      logic [SIZE_BITS_DEF-1:0] row;
      logic [COUNT_BITS-1:0]    count;
   } pixel_count_type;

   pixel_count_type          counts_due[$];
   logic [SIZE_BITS_DEF:0]   image_width;
   logic [SIZE_BITS_DEF:0]   image_height;

   function automatic longint clamp_q(input longint v);
      if (v > VAL_HI) return VAL_HI;
      if (v < VAL_LO) return VAL_LO;
      return v;
   endfunction

   // Escape-time count of one pixel for the given image size
   function automatic logic [COUNT_BITS-1:0] escape_count(
      input logic [SIZE_BITS_DEF-1:0] col,
      input logic [SIZE_BITS_DEF-1:0] row,
      input logic [SIZE_BITS_DEF:0]   w,
      input logic [SIZE_BITS_DEF:0]   h
   );
      longint cl, rw, wd, ht, span;
      longint c_re, c_im, z_re, z_im, sq_re, sq_im, cross_term;
      int     n;
      cl = longint'(col);
      rw = longint'(row);
      wd = longint'(w);
      ht = longint'(h);
      span = (wd < ht) ? wd : ht;
      // zero size: centre uses zero, divisor forced to one
      if (span == 0) span = 1;
      c_re = clamp_q(((2 * cl - wd) * C_UNIT) / span);
      c_im = clamp_q(((ht - 2 * rw) * C_UNIT) / span);
      z_re = 0;
      z_im = 0;
      n = 0;
      while (n < MAX_ITER_DEF) begin
         sq_re = (z_re * z_re) >>> FRAC;
         sq_im = (z_im * z_im) >>> FRAC;
         if (sq_re + sq_im >= ESCAPE_LIMIT) break;
         cross_term = (z_re * z_im) >>> (FRAC - 1);
         z_re = clamp_q(sq_re - sq_im + c_re);
         z_im = clamp_q(cross_term + c_im);
         n++;
      end
      if (n > COUNT_MAX) n = COUNT_MAX;
      return n[COUNT_BITS-1:0];
   endfunction

   // Register shadow, prediction on request transfer, compare on response transfer
   always @(posedge clock) begin : monitor
      pixel_count_type oldest;
      pixel_count_type fresh;
      if (reset) begin
         image_width = (SIZE_BITS_DEF+1)'(WIDTH_RESET);
         image_height = (SIZE_BITS_DEF+1)'(HEIGHT_RESET);
         counts_due.delete();
         pending_count <= 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_IMAGE_WIDTH:  image_width = csr_wdata;
               CSR_IMAGE_HEIGHT: image_height = csr_wdata;
               default: ;  // unmapped index, write dropped
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (counts_due.size() == 0) begin
               $display("%t ERROR unexpected count: expected none, actual %0d",
                        $time, rsp_iteration_count);
               fail_count <= fail_count + 1;
            end else begin
               oldest = counts_due.pop_front();
               if (rsp_iteration_count !== oldest.count) begin
                  $display("%t ERROR pixel (%0d,%0d) count: expected %0d, actual %0d",
                           $time, oldest.col, oldest.row, oldest.count, rsp_iteration_count);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_valid && req_ready) begin
            fresh.col = req_pixel_col;
            fresh.row = req_pixel_row;
            fresh.count = escape_count(req_pixel_col, req_pixel_row, image_width, image_height);
            counts_due.push_back(fresh);
         end
         pending_count <= counts_due.size();
      end
   end

endmodule

// ===== test/mandelbrot_escape_time_pixel_test.sv =====
// Testbench top for the escape-time pixel block: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module mandelbrot_escape_time_pixel_test;
   import mbep_pkg::*;

   // Indexes with no register behind them
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNMAPPED_LO = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNMAPPED_HI = 2'd3;
   localparam int RANDOM_PHASES   = 10;
   localparam int PIXELS_PER_PHASE = 150;
   localparam int TAIL_CYCLES     = 700;  // beyond worst-case pixel latency

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      csr_we = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = CSR_IMAGE_WIDTH;
   logic [SIZE_BITS_DEF:0]    csr_wdata = '0;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [SIZE_BITS_DEF-1:0]  req_pixel_col = '0;
   logic [SIZE_BITS_DEF-1:0]  req_pixel_row = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [COUNT_BITS-1:0]     rsp_iteration_count;

   int fail_count;
   int pending_count;
   int burst_left = 0;
   int image_w = WIDTH_RESET;
   int image_h = HEIGHT_RESET;
   int stall_mode = 0;
   int stall_left = 0;

   always #5 clock = ~clock;

   mandelbrot_escape_time_pixel dut (
      .clock               (clock),
      .reset               (reset),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_pixel_col       (req_pixel_col),
      .req_pixel_row       (req_pixel_row),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_iteration_count (rsp_iteration_count)
   );

   mandelbrot_escape_time_pixel_checker count_check (
      .clock               (clock),
      .reset               (reset),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_pixel_col       (req_pixel_col),
      .req_pixel_row       (req_pixel_row),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_iteration_count (rsp_iteration_count),
      .fail_count          (fail_count),
      .pending_count       (pending_count)
   );

   // Receiver: switches between always-ready, light and heavy back-pressure
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 2);
         stall_left <= $urandom_range(50, 500);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         0:       rsp_ready <= 1'b1;
         1:       rsp_ready <= ($urandom_range(0, 3) != 0);
         default: rsp_ready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   // One pixel transfer; bursts of random length separated by random gaps
   task automatic send_pixel(input int col, input int row);
      int gap;
      if (burst_left == 0) begin
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4: gap = 0;
            5, 6:          gap = $urandom_range(100, 700);
            default:       gap = $urandom_range(1, 20);
         endcase
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
      end
      burst_left--;
      req_valid     <= 1'b1;
      req_pixel_col <= SIZE_BITS_DEF'(col);
      req_pixel_row <= SIZE_BITS_DEF'(row);
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Hold off the sender until every predicted count has come back
   task automatic drain();
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   // Size update while idle, plus writes to the unmapped indexes
   task automatic set_image(input int w, input int h);
      csr_we    <= 1'b1;
      csr_index <= CSR_IMAGE_WIDTH;
      csr_wdata <= (SIZE_BITS_DEF+1)'(w);
      @(posedge clock);
      csr_index <= CSR_IMAGE_HEIGHT;
      csr_wdata <= (SIZE_BITS_DEF+1)'(h);
      @(posedge clock);
      csr_index <= CSR_UNMAPPED_LO;
      csr_wdata <= (SIZE_BITS_DEF+1)'($urandom);
      @(posedge clock);
      csr_index <= CSR_UNMAPPED_HI;
      csr_wdata <= (SIZE_BITS_DEF+1)'($urandom);
      @(posedge clock);
      csr_we <= 1'b0;
      image_w = w;
      image_h = h;
   endtask

   // Mostly pixels inside the image, some anywhere in the 12-bit range
   task automatic send_random_pixel();
      int col, row, wlim, hlim;
      wlim = (image_w > 4096) ? 4096 : image_w;
      hlim = (image_h > 4096) ? 4096 : image_h;
      if (wlim != 0 && hlim != 0 && $urandom_range(0, 4) != 0) begin
         col = $urandom_range(0, wlim - 1);
         row = $urandom_range(0, hlim - 1);
      end else begin
         col = $urandom_range(0, 4095);
         row = $urandom_range(0, 4095);
      end
      send_pixel(col, row);
   endtask

   initial begin : stimulus
      int phase, k, w, h;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset size 600x400: corners, centre, real-axis points, just off the image
      send_pixel(0, 0);
      send_pixel(4095, 4095);
      send_pixel(4095, 0);
      send_pixel(0, 4095);
      send_pixel(300, 200);
      send_pixel(150, 200);
      send_pixel(100, 200);
      send_pixel(375, 200);
      send_pixel(599, 399);
      send_pixel(600, 400);
      send_pixel(12'h555, 12'haaa);
      send_pixel(12'haaa, 12'h555);

      // Zero size: divisor taken as one
      drain();
      set_image(0, 0);
      send_pixel(0, 0);
      send_pixel(4095, 4095);

      // Largest register values
      drain();
      set_image(8191, 8191);
      send_pixel(4095, 4095);
      send_pixel(0, 0);

      // One-pixel image: c saturates
      drain();
      set_image(1, 1);
      send_pixel(4095, 0);
      send_pixel(0, 4095);
      send_pixel(0, 0);

      // Random phases over a spread of image sizes
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0:       begin w = WIDTH_RESET; h = HEIGHT_RESET; end
            1:       begin w = 0;    h = 480;  end
            2:       begin w = 640;  h = 0;    end
            3:       begin w = 1;    h = 1;    end
            4:       begin w = 8191; h = 8191; end
            5:       begin w = 4096; h = 4096; end
            6:       begin w = 96;   h = 64;   end
            7:       begin w = 2;    h = 3;    end
            default: begin w = $urandom_range(1, 4096); h = $urandom_range(1, 4096); end
         endcase
         drain();
         set_image(w, h);
         for (k = 0; k < PIXELS_PER_PHASE; k++) begin
            if ($urandom_range(0, 79) == 0) drain();
            send_random_pixel();
         end
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // Run limit
   initial begin
      #60_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
